// ===== src/wema_pkg.sv =====
// Shared types and constants for the weighted EMA sensor fusion block.
// No dependencies; every other file imports this package.
`default_nettype none
package wema_pkg;

	localparam int LANES = 4;

	typedef logic signed [17:0] reading_t;
	typedef logic signed [26:0] temp_t;
	typedef logic [43:0] coeff_t;
	typedef logic [2:0] cfg_index_t;

	// Register indexes
	localparam cfg_index_t REG_SENSORS_IN_USE = 3'd0;
	localparam cfg_index_t REG_COEFFS_FIRST   = 3'd1;
	localparam cfg_index_t REG_COEFFS_LAST    = 3'd4;

	localparam logic [2:0] SENSORS_RESET = 3'd1;

	localparam logic [10:0] SCALE     = 11'd1000;
	localparam logic [9:0]  ALPHA_MAX = 10'd1000;

	// x / 1000 == (x >> 3) / 125 == ((x >> 3) * RECIP_125) >> RECIP_SHIFT for x < 2^34
	localparam logic signed [31:0] RECIP_125  = 32'sd1099511628;
	localparam int                 RECIP_SHIFT = 37;

	localparam logic signed [27:0] OUT_MAX = 28'sd67108863;
	localparam logic signed [27:0] OUT_MIN = -28'sd67108864;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_A,
		ST_MUL_B,
		ST_ABS,
		ST_DIV_MUL,
		ST_DIV_FIX,
		ST_MUL_W,
		ST_DONE
	} wema_state_t;

endpackage
`default_nettype wire

// ===== src/wema_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on wema_pkg.
`default_nettype none
interface wema_cfg_if import wema_pkg::*; ();
	logic       valid;
	logic       ready;
	cfg_index_t index;
	coeff_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/wema_in_if.sv =====
// Input channel: one reading per sensor lane per transaction.
// Depends on wema_pkg.
`default_nettype none
interface wema_in_if import wema_pkg::*; ();
	logic     valid;
	logic     ready;
	reading_t reading_0;
	reading_t reading_1;
	reading_t reading_2;
	reading_t reading_3;

	modport source (output valid, output reading_0, output reading_1, output reading_2,
		output reading_3, input ready);
	modport sink (input valid, input reading_0, input reading_1, input reading_2,
		input reading_3, output ready);
endinterface
`default_nettype wire

// ===== src/wema_out_if.sv =====
// Output channel: fused virtual temperature.
// Depends on wema_pkg.
`default_nettype none
interface wema_out_if import wema_pkg::*; ();
	logic  valid;
	logic  ready;
	temp_t virtual_temp;

	modport source (output valid, output virtual_temp, input ready);
	modport sink (input valid, input virtual_temp, output ready);
endinterface
`default_nettype wire

// ===== src/weighted_ema_sensor_fusion.sv =====
// Top level: weighted EMA sensor fusion with one shared 32x32 multiplier.
// Depends on wema_pkg, wema_cfg_if, wema_in_if, wema_out_if.
//
// Usage:
//   cfg    - register writes (index 0: lanes in use, 1..4: packed lane coefficients).
//            Always ready; write only while the block is idle.
//   sample - one transaction carries one reading per lane. Ready only when idle.
//   result - one transaction per accepted sample, held until taken.
// Per lane in use a sequencer drives the single multiplier: alpha*x, (1000-alpha)*f,
// a reciprocal multiply for the divide by 1000, weight*f and a second divide.
// An unseeded lane (zero filter state) is seeded with its offset-corrected reading and
// skips alpha*x, (1000-alpha)*f and the first divide. The next sample is accepted once
// the result is registered, in the cycle after at the earliest.
// Reset clears all filter state (unseeded), coefficients to zero, lanes in use to 1.
// If the receiver stalls, the result holds and a finished computation waits in
// the last state until the output register frees; no sample is accepted meanwhile.
`default_nettype none
module weighted_ema_sensor_fusion import wema_pkg::*; #(
	parameter int NUM_SENSORS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	wema_cfg_if.sink    cfg,
	wema_in_if.sink     sample,
	wema_out_if.source  result
);

	localparam int LANE_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam logic [2:0] ACT_MAX = 3'((NUM_SENSORS < LANES) ? NUM_SENSORS : LANES);

	wema_state_t state_q, state_d;

	logic [2:0]        sensors_q;
	coeff_t            coeff_q [LANES];
	logic signed [18:0] filt_q [NUM_SENSORS];
	reading_t          rd_q [LANES];

	logic [2:0]         lane_q;
	logic [2:0]         act_q;
	logic [9:0]         alpha_q;
	logic signed [18:0] x_q;
	logic signed [18:0] f_q;
	logic signed [29:0] prod_q;
	logic signed [35:0] num_q;
	logic [33:0]        num_abs_q;
	logic               neg_q;
	logic [24:0]        quot_q;
	logic               w_phase_q;
	logic signed [27:0] acc_q;
	logic               out_valid_q;
	temp_t              out_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;

	logic               sample_acc;
	logic               out_load;
	logic               last_lane;
	coeff_t             coeff_sel;
	reading_t           rd_sel;
	logic [9:0]         alpha_raw;
	logic signed [17:0] offset_sel;
	logic signed [18:0] x_cur;
	logic signed [18:0] f_cur;
	logic signed [25:0] div_res;
	logic signed [27:0] acc_sat;
	logic [2:0]         act_cur;

	assign coeff_sel  = coeff_q[lane_q[1:0]];
	assign rd_sel     = rd_q[lane_q[1:0]];
	assign alpha_raw  = coeff_sel[9:0];
	assign offset_sel = $signed(coeff_sel[27:10]);
	assign x_cur      = 19'(rd_sel) - 19'(offset_sel);
	assign f_cur      = filt_q[lane_q[LANE_W-1:0]];
	assign div_res    = neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
	assign last_lane  = (lane_q + 3'd1) == act_q;
	assign act_cur    = (sensors_q > ACT_MAX) ? ACT_MAX : sensors_q;
	assign mul_p      = mul_a * mul_b;
	assign sample_acc = sample.valid && sample.ready;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	always_comb begin
		if (acc_q > OUT_MAX) begin
			acc_sat = OUT_MAX;
		end else if (acc_q < OUT_MIN) begin
			acc_sat = OUT_MIN;
		end else begin
			acc_sat = acc_q;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_acc) begin
					state_d = (act_cur == 3'd0) ? ST_DONE : ST_PREP;
				end
			end
			ST_PREP:    state_d = (f_cur == '0) ? ST_MUL_W : ST_MUL_A;
			ST_MUL_A:   state_d = ST_MUL_B;
			ST_MUL_B:   state_d = ST_ABS;
			ST_ABS:     state_d = ST_DIV_MUL;
			ST_DIV_MUL: state_d = ST_DIV_FIX;
			ST_DIV_FIX: begin
				if (!w_phase_q) begin
					state_d = ST_MUL_W;
				end else begin
					state_d = last_lane ? ST_DONE : ST_PREP;
				end
			end
			ST_MUL_W:   state_d = ST_ABS;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs and multiplier operand select
	always_comb begin
		sample.ready        = (state_q == ST_IDLE);
		cfg.ready           = 1'b1;
		result.valid        = out_valid_q;
		result.virtual_temp = out_q;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_A: begin
				mul_a = 32'(x_q);
				mul_b = $signed({22'd0, alpha_q});
			end
			ST_MUL_B: begin
				mul_a = 32'(f_q);
				mul_b = $signed({21'd0, SCALE - {1'b0, alpha_q}});
			end
			ST_MUL_W: begin
				mul_a = 32'(f_q);
				mul_b = 32'($signed(coeff_sel[43:28]));
			end
			ST_DIV_MUL: begin
				mul_a = $signed({1'b0, num_abs_q[33:3]});
				mul_b = RECIP_125;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Control and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sensors_q   <= SENSORS_RESET;
			out_valid_q <= 1'b0;
			lane_q      <= '0;
			act_q       <= '0;
			w_phase_q   <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				coeff_q[i] <= '0;
			end
			for (int i = 0; i < NUM_SENSORS; i++) begin
				filt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_SENSORS_IN_USE) begin
					sensors_q <= cfg.data[2:0];
				end else if (cfg.index >= REG_COEFFS_FIRST && cfg.index <= REG_COEFFS_LAST) begin
					coeff_q[2'(cfg.index - REG_COEFFS_FIRST)] <= cfg.data;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					lane_q <= '0;
					act_q  <= act_cur;
				end
				ST_PREP: begin
					w_phase_q <= (f_cur == '0);
					if (f_cur == '0) begin
						filt_q[lane_q[LANE_W-1:0]] <= x_cur;
					end
				end
				ST_MUL_B:   w_phase_q <= 1'b0;
				ST_MUL_W:   w_phase_q <= 1'b1;
				ST_DIV_FIX: begin
					if (!w_phase_q) begin
						filt_q[lane_q[LANE_W-1:0]] <= 19'(div_res);
					end else if (!last_lane) begin
						lane_q <= lane_q + 3'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (sample_acc) begin
			rd_q[0] <= sample.reading_0;
			rd_q[1] <= sample.reading_1;
			rd_q[2] <= sample.reading_2;
			rd_q[3] <= sample.reading_3;
			acc_q   <= '0;
		end
		unique case (state_q)
			ST_PREP: begin
				x_q     <= x_cur;
				alpha_q <= (alpha_raw > ALPHA_MAX) ? ALPHA_MAX : alpha_raw;
				f_q     <= (f_cur == '0) ? x_cur : f_cur;
			end
			ST_MUL_A:   prod_q <= $signed(mul_p[29:0]);
			ST_MUL_B:   num_q <= 36'(prod_q) + 36'($signed(mul_p[29:0]));
			ST_MUL_W:   num_q <= $signed(mul_p[35:0]);
			ST_ABS: begin
				num_abs_q <= num_q[35] ? 34'(-num_q) : 34'(num_q);
				neg_q     <= num_q[35];
			end
			ST_DIV_MUL: quot_q <= mul_p[RECIP_SHIFT+24:RECIP_SHIFT];
			ST_DIV_FIX: begin
				if (!w_phase_q) begin
					f_q <= 19'(div_res);
				end else begin
					acc_q <= acc_q + 28'(div_res);
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_q <= 27'(acc_sat);
				end
			end
			default: begin
			end
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_acc |=> (state_q != ST_IDLE))
		else $error("sequencer idle after sample accept");

	a_lane_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_DONE) |-> (lane_q < act_q))
		else $error("lane index beyond lanes in use");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_load) |=> (state_q == ST_DONE && !sample.ready))
		else $error("left done state without loading result");

endmodule
`default_nettype wire

// ===== sim/weighted_ema_sensor_fusion_tb.sv =====
// Self-checking testbench for weighted_ema_sensor_fusion: directed and random readings under
// random idling and a long result stall, checked against an in-bench filter and sum predictor.
// Depends on wema_pkg, wema_cfg_if, wema_in_if, wema_out_if and the block itself.
module weighted_ema_sensor_fusion_tb;
	import wema_pkg::*;

	localparam int         NUM_SENSORS     = 4;
	localparam int         ACTIVE_MAX      = (NUM_SENSORS < LANES) ? NUM_SENSORS : LANES;
	localparam longint     PER_MILLE       = 1000;
	localparam int         WATCHDOG_LIMIT  = 5000;
	localparam int         HOLD_OFF_CYCLES = 600;
	localparam int         SETTLE_CYCLES   = 2 + 10 * LANES + 10;
	localparam reading_t   RD_MAX          = 18'sh1FFFF;
	localparam reading_t   RD_MIN          = 18'sh20000;
	localparam cfg_index_t REG_INDEX_TOP   = '1;
	localparam coeff_t     COEFF_ALL_ONES  = '1;

	logic clk;
	logic arst_n;

	wema_cfg_if cfg_bus ();
	wema_in_if  smp_bus ();
	wema_out_if res_bus ();

	weighted_ema_sensor_fusion #(.NUM_SENSORS(NUM_SENSORS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.sample (smp_bus),
		.result (res_bus)
	);

	logic [2:0]         lanes_cfg;
	coeff_t             coeff_reg [LANES];
	logic signed [18:0] ema_state [LANES];
	temp_t              expected_temps [$];
	int                 phase_base [LANES];

	int unsigned err_count    = 0;
	int unsigned n_samples    = 0;
	int unsigned n_results    = 0;
	int unsigned n_writes     = 0;
	int unsigned hold_request = 0;
	int unsigned quiet_cycles = 0;
	bit          tx_idling    = 1'b1;
	bit          rx_idling    = 1'b1;
	bit          tx_calm      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic coeff_t pack_coeff(input int alpha, input int offset, input int weight);
		return {weight[15:0], offset[17:0], alpha[9:0]};
	endfunction

	// One poll through the lane filters; updates the filter state.
	function automatic temp_t fuse_readings(input reading_t r0, input reading_t r1,
		input reading_t r2, input reading_t r3);
		reading_t rd [LANES];
		longint   alpha, offset, weight, x, f, acc;
		int       active, i;
		rd[0] = r0;
		rd[1] = r1;
		rd[2] = r2;
		rd[3] = r3;
		active = (lanes_cfg > ACTIVE_MAX) ? ACTIVE_MAX : lanes_cfg;
		acc = 0;
		for (i = 0; i < active; i++) begin
			alpha = coeff_reg[i][9:0];
			if (alpha > PER_MILLE)
				alpha = PER_MILLE;
			offset = $signed(coeff_reg[i][27:10]);
			weight = $signed(coeff_reg[i][43:28]);
			x = rd[i] - offset;
			f = ema_state[i];
			if (f == 0)
				f = x;
			else
				f = (alpha * x + (PER_MILLE - alpha) * f) / PER_MILLE;
			ema_state[i] = f[18:0];
			acc += (weight * f) / PER_MILLE;
		end
		if (acc > OUT_MAX)
			acc = OUT_MAX;
		if (acc < OUT_MIN)
			acc = OUT_MIN;
		return acc[26:0];
	endfunction

	function automatic reading_t random_reading(input int lane);
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2: return reading_t'($urandom);
			3: return reading_t'(coeff_reg[lane][27:10]);
			default: begin
				v = phase_base[lane] + int'($urandom_range(0, 4000)) - 2000;
				if (v > 131071)
					v = 131071;
				if (v < -131072)
					v = -131072;
				return v[17:0];
			end
		endcase
	endfunction

	function automatic coeff_t random_coeff();
		int a, o, w;
		case ($urandom_range(0, 9))
			0: a = 0;
			1: a = 1000;
			2: a = $urandom_range(1001, 1023);
			default: a = $urandom_range(1, 999);
		endcase
		o = ($urandom_range(0, 3) == 0) ? int'($urandom) : int'($urandom_range(0, 8000)) - 4000;
		w = ($urandom_range(0, 2) == 0) ? int'($urandom) : int'($urandom_range(0, 4000)) - 2000;
		return pack_coeff(a, o, w);
	endfunction

	// Leaves valid high so back-to-back transactions need no second assignment in a step.
	task automatic send_sample(input reading_t r0, input reading_t r1, input reading_t r2,
		input reading_t r3);
		if (tx_idling && !tx_calm && $urandom_range(0, 3) == 0) begin
			smp_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		if ($urandom_range(0, 63) == 0)
			tx_calm = !tx_calm;
		smp_bus.valid     <= 1'b1;
		smp_bus.reading_0 <= r0;
		smp_bus.reading_1 <= r1;
		smp_bus.reading_2 <= r2;
		smp_bus.reading_3 <= r3;
		@(posedge clk);
		while (!smp_bus.ready) @(posedge clk);
		expected_temps.push_back(fuse_readings(r0, r1, r2, r3));
		n_samples++;
	endtask

	task automatic send_random_sample();
		send_sample(random_reading(0), random_reading(1), random_reading(2), random_reading(3));
	endtask

	task automatic drain_results();
		smp_bus.valid <= 1'b0;
		@(posedge clk);
		while (expected_temps.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input coeff_t value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		n_writes++;
		if (idx == REG_SENSORS_IN_USE)
			lanes_cfg = value[2:0];
		else if (idx >= REG_COEFFS_FIRST && idx <= REG_COEFFS_LAST)
			coeff_reg[idx - REG_COEFFS_FIRST] = value;
	endtask

	task automatic cfg_idle();
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic test_reset_state();
		send_sample(RD_MAX, RD_MIN, RD_MAX, RD_MIN);
		send_sample(RD_MIN, RD_MAX, 0, 0);
		drain_results();
	endtask

	task automatic test_full_lanes();
		write_register(REG_SENSORS_IN_USE, coeff_t'(ACTIVE_MAX));
		write_register(REG_COEFFS_FIRST, pack_coeff(500, 0, 32767));
		write_register(REG_COEFFS_FIRST + 3'd1, pack_coeff(1023, -131072, -32768));
		write_register(REG_COEFFS_FIRST + 3'd2, pack_coeff(0, 131071, 1000));
		write_register(REG_COEFFS_FIRST + 3'd3, pack_coeff(1000, 1234, -1));
		cfg_idle();
		send_sample(RD_MAX, RD_MAX, RD_MIN, 0);
		send_sample(RD_MIN, RD_MIN, RD_MAX, 1234);
		send_sample(0, 1, -1, RD_MAX);
		send_sample(RD_MAX, RD_MIN, 0, RD_MIN);
		drain_results();
	endtask

	// Filter landing on zero, by a full-weight reading on the offset and by truncation.
	task automatic test_reseed_zero();
		write_register(REG_SENSORS_IN_USE, coeff_t'(1));
		write_register(REG_COEFFS_FIRST, pack_coeff(1000, 5000, 1000));
		cfg_idle();
		send_sample(7000, RD_MAX, RD_MAX, RD_MAX);
		send_sample(5000, RD_MIN, RD_MIN, RD_MIN);
		send_sample(-3000, 0, 0, 0);
		send_sample(5000, 0, 0, 0);
		send_sample(5000, 0, 0, 0);
		drain_results();
		write_register(REG_COEFFS_FIRST, pack_coeff(1, 5000, 1000));
		cfg_idle();
		send_sample(5001, 0, 0, 0);
		send_sample(5000, 0, 0, 0);
		send_sample(4000, 0, 0, 0);
		drain_results();
	endtask

	task automatic test_lane_count();
		write_register(REG_SENSORS_IN_USE, coeff_t'(0));
		cfg_idle();
		send_sample(RD_MAX, RD_MAX, RD_MAX, RD_MAX);
		send_sample(RD_MIN, RD_MIN, RD_MIN, RD_MIN);
		drain_results();
		write_register(REG_SENSORS_IN_USE, coeff_t'(7));
		cfg_idle();
		send_sample(1000, -2000, 3000, -4000);
		send_sample(RD_MIN, RD_MAX, RD_MIN, RD_MAX);
		drain_results();
		write_register(REG_SENSORS_IN_USE, coeff_t'(5));
		cfg_idle();
		send_sample(-500, 600, -700, 800);
		drain_results();
	endtask

	task automatic test_register_extremes();
		int i;
		for (i = 0; i < LANES; i++)
			write_register(REG_COEFFS_FIRST + cfg_index_t'(i), COEFF_ALL_ONES);
		for (i = REG_COEFFS_LAST + 1; i <= REG_INDEX_TOP; i++)
			write_register(cfg_index_t'(i), COEFF_ALL_ONES);
		write_register(REG_SENSORS_IN_USE, coeff_t'(ACTIVE_MAX));
		cfg_idle();
		send_sample(RD_MAX, RD_MIN, RD_MAX, RD_MIN);
		send_sample(RD_MIN, RD_MAX, RD_MIN, RD_MAX);
		drain_results();
		for (i = 0; i < LANES; i++)
			write_register(REG_COEFFS_FIRST + cfg_index_t'(i), '0);
		cfg_idle();
		send_sample(12345, -12345, 54321, -54321);
		drain_results();
	endtask

	task automatic test_random_phases(input int unsigned target);
		int i, lanes, count;
		while (n_samples < target) begin
			drain_results();
			case ($urandom_range(0, 9))
				0: lanes = 0;
				1: lanes = $urandom_range(5, 7);
				default: lanes = $urandom_range(1, 4);
			endcase
			write_register(REG_SENSORS_IN_USE, coeff_t'(lanes));
			for (i = 0; i < LANES; i++)
				if ($urandom_range(0, 2) != 0)
					write_register(REG_COEFFS_FIRST + cfg_index_t'(i), random_coeff());
			if ($urandom_range(0, 7) == 0)
				write_register(cfg_index_t'($urandom_range(REG_COEFFS_LAST + 1, REG_INDEX_TOP)),
					coeff_t'({$urandom, $urandom}));
			cfg_idle();
			for (i = 0; i < LANES; i++)
				phase_base[i] = int'($urandom_range(0, 240000)) - 120000;
			count = $urandom_range(20, 80);
			repeat (count) send_random_sample();
		end
	endtask

	// Result side held off while samples keep coming, so the block backs up into its input.
	task automatic test_backpressure();
		tx_idling = 1'b0;
		hold_request = HOLD_OFF_CYCLES;
		repeat (12) send_random_sample();
		tx_idling = 1'b1;
	endtask

	task automatic test_steady_stream(input int count);
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		repeat (count) send_random_sample();
	endtask

	initial begin : result_ready
		int unsigned span;
		bit          calm;
		calm = 1'b0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				calm = !calm;
			if (hold_request != 0) begin
				span = hold_request;
				hold_request = 0;
				res_bus.ready <= 1'b0;
			end else if (rx_idling && !calm && $urandom_range(0, 7) == 0) begin
				span = $urandom_range(1, 18);
				res_bus.ready <= 1'b0;
			end else begin
				span = 1;
				res_bus.ready <= 1'b1;
			end
			repeat (span - 1) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		temp_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			n_results++;
			if (expected_temps.size() == 0) begin
				report_mismatch($sformatf("virtual_temp %0d with no sample outstanding",
					res_bus.virtual_temp));
			end else begin
				want = expected_temps.pop_front();
				if (res_bus.virtual_temp !== want)
					report_mismatch($sformatf("virtual_temp got %0d expected %0d",
						res_bus.virtual_temp, want));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cfg_bus.valid && cfg_bus.ready) || (smp_bus.valid && smp_bus.ready)
			|| (res_bus.valid && res_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("weighted_ema_sensor_fusion_tb NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		arst_n            <= 1'b0;
		smp_bus.valid     <= 1'b0;
		smp_bus.reading_0 <= '0;
		smp_bus.reading_1 <= '0;
		smp_bus.reading_2 <= '0;
		smp_bus.reading_3 <= '0;
		cfg_bus.valid     <= 1'b0;
		cfg_bus.index     <= REG_SENSORS_IN_USE;
		cfg_bus.data      <= '0;
		lanes_cfg = SENSORS_RESET;
		for (i = 0; i < LANES; i++) begin
			coeff_reg[i]  = '0;
			ema_state[i]  = '0;
			phase_base[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_full_lanes();
		test_reseed_zero();
		test_lane_count();
		test_register_extremes();
		test_random_phases(780);
		test_backpressure();
		test_steady_stream(110);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d samples, %0d results and %0d register writes over lane counts 0-7,",
			n_samples, n_results, n_writes);
		$display("alpha saturation, re-seeding after a zero filter and a %0d-cycle result stall",
			HOLD_OFF_CYCLES);
		if (err_count == 0 && expected_temps.size() == 0) begin
			$display("weighted_ema_sensor_fusion_tb OK");
		end else begin
			$display("weighted_ema_sensor_fusion_tb NOT OK");
		end
		$finish;
	end

endmodule
